FILE: rtl/ieq_pkg.sv
// package: constants, start gain function and arctangent table for the euler to quaternion converter
package ieq_pkg;

    localparam int QUAT_WIDTH_DEF  = 16;
    localparam int TRIG_STAGES_DEF = 16;
    localparam int ANG_W   = 32;
    localparam int CW      = 34;
    localparam logic signed [ANG_W-1:0] ANG_90  = 32'sd377487360;
    localparam logic signed [ANG_W-1:0] ANG_180 = 32'sd754974720;
    localparam longint GAIN_INF_Q30  = 64'd652032874;
    localparam longint GAIN_CORR_Q30 = 64'd434688583;

    function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
        logic signed [ANG_W-1:0] r;
        case (i)
            0:  r = 32'sd188743680;
            1:  r = 32'sd111421900;
            2:  r = 32'sd58872272;
            3:  r = 32'sd29884485;
            4:  r = 32'sd15000234;
            5:  r = 32'sd7507429;
            6:  r = 32'sd3754631;
            7:  r = 32'sd1877430;
            8:  r = 32'sd938729;
            9:  r = 32'sd469366;
            10: r = 32'sd234683;
            11: r = 32'sd117342;
            12: r = 32'sd58671;
            13: r = 32'sd29335;
            14: r = 32'sd14668;
            15: r = 32'sd7334;
            16: r = 32'sd3667;
            17: r = 32'sd1833;
            18: r = 32'sd917;
            19: r = 32'sd458;
            20: r = 32'sd229;
            21: r = 32'sd115;
            22: r = 32'sd57;
            23: r = 32'sd29;
            24: r = 32'sd14;
            25: r = 32'sd7;
            26: r = 32'sd4;
            27: r = 32'sd2;
            28: r = 32'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [CW-1:0] start_gain(input int n);
        longint g;
        g = GAIN_INF_Q30;
        if (2 * n < 31) g = g + (GAIN_CORR_Q30 >> (2 * n));
        return CW'(g);
    endfunction

endpackage

FILE: rtl/ieq_cordic.sv
// module: pipelined degree-domain cordic giving sine and cosine of a half angle
module ieq_cordic
    import ieq_pkg::*;
#(
    parameter int TRIG_STAGES = TRIG_STAGES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [16:0]   angle,
    output logic                 out_valid,
    output logic signed [CW-1:0] sin_q30,
    output logic signed [CW-1:0] cos_q30
);

    localparam int N = (TRIG_STAGES > 32) ? 32 : TRIG_STAGES;

    logic                 v_reg [0:N];
    logic signed [CW-1:0] x_reg [0:N];
    logic signed [CW-1:0] y_reg [0:N];
    logic signed [ANG_W-1:0] z_reg [0:N];
    logic                 neg_reg [0:N];

    logic signed [ANG_W-1:0] z0;
    logic signed [ANG_W-1:0] z_next;
    logic                    neg_next;

    always_comb
    begin
        z0 = ANG_W'(angle) <<< 15;
        z_next = z0;
        neg_next = 1'b0;
        if (z0 > ANG_90)
        begin
            z_next = z0 - ANG_180;
            neg_next = 1'b1;
        end
        else if (z0 < -ANG_90)
        begin
            z_next = z0 + ANG_180;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= start_gain(N);
        y_reg[0]   <= '0;
        z_reg[0]   <= z_next;
        neg_reg[0] <= neg_next;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            neg_reg[i+1] <= neg_reg[i];
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_deg(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_deg(i);
            end
        end
    end

    assign out_valid = v_reg[N];
    assign sin_q30   = neg_reg[N] ? -y_reg[N] : y_reg[N];
    assign cos_q30   = neg_reg[N] ? -x_reg[N] : x_reg[N];

endmodule

FILE: rtl/imu_euler_to_quaternion.sv
// top level: euler angle sample to zyx unit quaternion, fully pipelined
// throughput: one word per cycle; busy is held low, so start may be high every cycle
// the pipeline length is set by the frame stage, the cordic entry register and stage chain,
// two multiply stages and the rounding/saturation output register
// reset clears only the valid bits; done stays low until the first word drains out
module imu_euler_to_quaternion
    import ieq_pkg::*;
#(
    parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF,
    parameter int TRIG_STAGES = TRIG_STAGES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [15:0]           roll_angle,
    input  logic signed [15:0]           pitch_angle,
    input  logic signed [15:0]           yaw_angle,
    output logic                         done,
    output logic signed [QUAT_WIDTH-1:0] quat_w,
    output logic signed [QUAT_WIDTH-1:0] quat_x,
    output logic signed [QUAT_WIDTH-1:0] quat_y,
    output logic signed [QUAT_WIDTH-1:0] quat_z
);

    localparam int SH = 62 - QUAT_WIDTH;
    localparam int PW = 2 * CW;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (SH - 1);
    localparam logic signed [PW-1:0] LIM  = PW'(1) <<< (QUAT_WIDTH - 2);

    // the pipeline never stalls, so the block is always ready
    assign busy = 1'b0;

    // frame stage: robot frame negates pitch and yaw, yaw wraps once
    logic                v_f_reg;
    logic signed [16:0]  roll_f_reg, pitch_f_reg, yaw_f_reg;
    logic signed [17:0]  yaw_neg, yaw_wrap;

    always_comb
    begin
        yaw_neg  = -18'(yaw_angle);
        yaw_wrap = yaw_neg;
        if (yaw_neg > 18'sd11520)
            yaw_wrap = yaw_neg - 18'sd23040;
        else if (yaw_neg < -18'sd11520)
            yaw_wrap = yaw_neg + 18'sd23040;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_f_reg <= 1'b0;
        else
            v_f_reg <= start;
    end

    // one extra bit so negated -32768 stays +32768
    always_ff @(posedge clk)
    begin
        roll_f_reg  <= 17'(roll_angle);
        pitch_f_reg <= -17'(pitch_angle);
        yaw_f_reg   <= yaw_wrap[16:0];
    end

    // three cordic lanes share one timing; only the roll lane's valid is carried on
    logic                 v_c;
    logic                 v_p_unused, v_y_unused;
    logic signed [CW-1:0] sr, cr, sp, cp, sy, cy;

    ieq_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_roll
    (
        .clk(clk), .rst_n(rst_n), .in_valid(v_f_reg), .angle(roll_f_reg),
        .out_valid(v_c), .sin_q30(sr), .cos_q30(cr)
    );
    ieq_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_pitch
    (
        .clk(clk), .rst_n(rst_n), .in_valid(v_f_reg), .angle(pitch_f_reg),
        .out_valid(v_p_unused), .sin_q30(sp), .cos_q30(cp)
    );
    ieq_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_yaw
    (
        .clk(clk), .rst_n(rst_n), .in_valid(v_f_reg), .angle(yaw_f_reg),
        .out_valid(v_y_unused), .sin_q30(sy), .cos_q30(cy)
    );

    // first product stage: yaw-pitch pairs back to q30, roll terms delayed alongside
    logic                 v_m1_reg;
    logic signed [CW-1:0] cycp_reg, sysp_reg, sycp_reg, cysp_reg, sr_reg, cr_reg;
    logic signed [PW-1:0] p_cycp, p_sysp, p_sycp, p_cysp;

    assign p_cycp = PW'(cy) * PW'(cp);
    assign p_sysp = PW'(sy) * PW'(sp);
    assign p_sycp = PW'(sy) * PW'(cp);
    assign p_cysp = PW'(cy) * PW'(sp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_m1_reg <= 1'b0;
        else
            v_m1_reg <= v_c;
    end

    always_ff @(posedge clk)
    begin
        cycp_reg <= CW'(p_cycp >>> 30);
        sysp_reg <= CW'(p_sysp >>> 30);
        sycp_reg <= CW'(p_sycp >>> 30);
        cysp_reg <= CW'(p_cysp >>> 30);
        sr_reg   <= sr;
        cr_reg   <= cr;
    end

    // second product stage: eight q60 products
    logic                 v_m2_reg;
    logic signed [PW-1:0] a_reg [0:7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_m2_reg <= 1'b0;
        else
            v_m2_reg <= v_m1_reg;
    end

    always_ff @(posedge clk)
    begin
        a_reg[0] <= PW'(cycp_reg) * PW'(cr_reg);
        a_reg[1] <= PW'(sysp_reg) * PW'(sr_reg);
        a_reg[2] <= PW'(cycp_reg) * PW'(sr_reg);
        a_reg[3] <= PW'(sysp_reg) * PW'(cr_reg);
        a_reg[4] <= PW'(sycp_reg) * PW'(sr_reg);
        a_reg[5] <= PW'(cysp_reg) * PW'(cr_reg);
        a_reg[6] <= PW'(sycp_reg) * PW'(cr_reg);
        a_reg[7] <= PW'(cysp_reg) * PW'(sr_reg);
    end

    function automatic logic signed [QUAT_WIDTH-1:0] to_out(input logic signed [PW-1:0] s);
        logic signed [PW-1:0] v;
        v = (s + HALF) >>> SH;
        if (v > LIM)
            v = LIM;
        else if (v < -LIM)
            v = -LIM;
        return v[QUAT_WIDTH-1:0];
    endfunction

    // sum, round and saturate into the output register
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_m2_reg;
    end

    always_ff @(posedge clk)
    begin
        quat_w <= to_out(a_reg[0] + a_reg[1]);
        quat_x <= to_out(a_reg[2] - a_reg[3]);
        quat_y <= to_out(a_reg[4] + a_reg[5]);
        quat_z <= to_out(a_reg[6] - a_reg[7]);
    end

    assign done = done_reg;

    // the lanes must agree on timing
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (v_c == v_p_unused) && (v_c == v_y_unused))
        else $error("cordic lanes out of step");

    // a word leaving the cordic shows up on the ports after the two product stages and the output register
    a_tail_latency: assert property (@(posedge clk) disable iff (!rst_n)
        v_c |-> ##3 done)
        else $error("output word lost in product stages");

    // no word appears without one having left the cordic
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v_m2_reg))
        else $error("output strobe without a word");

endmodule
